/* rtl/fctf_pkg.sv */
// Shared types, constants and helper functions for the transmit framer.
// No dependencies; imported by fctf_chain and the top level.

package fctf_pkg;

  // Default message length limit in bytes
  localparam int FCTF_MAX_MSG = 64;

  // Bytes per check group
  localparam int FCTF_GROUP_LEN = 8;

  // Line bytes
  localparam logic [7:0] FCTF_START_BYTE = 8'h0D;
  localparam logic [7:0] FCTF_SPACE_BYTE = 8'h20;
  localparam logic [7:0] FCTF_END_BYTE   = 8'h0A;
  localparam logic [7:0] FCTF_FILL_BYTE  = 8'h00;

  // Offset added to a group check outside the printable window
  localparam logic [7:0] FCTF_CHECK_OFFSET = 8'd64;

  // Configuration register indexes (word address bits)
  localparam logic [1:0] FCTF_REG_CHECK_ENABLE   = 2'd0;
  localparam logic [1:0] FCTF_REG_SUPPRESS_START = 2'd1;
  localparam logic [1:0] FCTF_REG_SUPPRESS_END   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_CHECK,
    ST_END,
    ST_FILL
  } fctf_state_t;

  // Control from the sequencer to the check chain
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_val;
  } fctf_chain_ctl_t;

  // Map a group XOR to its check character: values whose top bits are not 01
  // (below 64 as a signed byte) get 64 added modulo 256
  function automatic logic [7:0] fctf_adjust(input logic [7:0] v);
    logic [7:0] r;
    r = (v[7:6] != 2'b01) ? (v + FCTF_CHECK_OFFSET) : v;
    return r;
  endfunction

endpackage

/* rtl/fctf_cell.sv */
// One cell of the group check chain: holds one completed group XOR.
// Depends on nothing but its neighbors; instantiated by fctf_chain.

module fctf_cell (
  input  logic       clk,
  input  logic       push,
  input  logic       pop,
  input  logic [7:0] from_left,
  input  logic [7:0] from_right,
  output logic [7:0] val
);

  logic [7:0] val_r;
  logic [7:0] val_nxt;

  // Shift right on push, left on pop, else hold
  always_comb begin
    val_nxt = val_r;
    if (push) begin
      val_nxt = from_left;
    end else if (pop) begin
      val_nxt = from_right;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

/* rtl/fctf_chain.sv */
// Stack of group checks built as a row of fctf_cell; newest group at cell 0.
// Uses fctf_pkg for the control struct; instantiated by the top level.

module fctf_chain #(
  parameter int NUM_GROUPS = 8
) (
  input  logic                     clk,
  input  fctf_pkg::fctf_chain_ctl_t ctl,
  output logic [7:0]               head
);

  import fctf_pkg::*;

  logic [7:0] cell_val [NUM_GROUPS];

  // Cell 0 takes the new group on push; the last cell refills with itself on pop
  for (genvar i = 0; i < NUM_GROUPS; i++) begin : g_cell
    logic [7:0] left_val;
    logic [7:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = ctl.push_val;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == NUM_GROUPS - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    fctf_cell u_cell (
      .clk        (clk),
      .push       (ctl.push),
      .pop        (ctl.pop),
      .from_left  (left_val),
      .from_right (right_val),
      .val        (cell_val[i])
    );
  end

  assign head = cell_val[0];

endmodule

/* rtl/frame_check_transmit_framer_unit.sv */
// Transmit framer top level: sequencer, counters, registers and output stage.
// Depends on fctf_pkg and fctf_chain (which uses fctf_cell).
//
// Usage:
//   Input channel (in_valid/in_stall): one message byte per request, with
//   in_last_byte set on the final byte. Output channel (out_valid/out_stall):
//   one line byte per request, out_frame_end on the final byte of the frame and
//   out_status set there when bytes beyond MAX_MSG were dropped.
//   Configuration is written over the APB-style cfg_ port while idle.
// Output sequence:
//   A result is registered in a single output register and appears in the
//   cycle after the request that causes it. Middle bytes of a message flow at
//   one per cycle while the output is not stalled. The first byte emits the
//   start byte (a space when suppressed), then the data. The last byte is
//   followed by one check per stored group (up to MAX_MSG/8 rounded up) when
//   enabled, one chain cell shift per check, then the end byte unless suppressed.
// Reset: counters clear, check_enable returns to 1, suppress flags to 0, and
//   the output register empties. Check cells hold no reset value.
// Stall: a stalled output holds its byte; in_stall rises until it is taken.

module frame_check_transmit_framer_unit #(
  parameter int MAX_MSG = fctf_pkg::FCTF_MAX_MSG
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic        out_status,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import fctf_pkg::*;

  localparam int NUM_GROUPS = (MAX_MSG + FCTF_GROUP_LEN - 1) / FCTF_GROUP_LEN;
  localparam int CW = $clog2(MAX_MSG + 1);
  localparam int GW = $clog2(NUM_GROUPS + 1);

  // Registers
  fctf_state_t   state_r, state_nxt;
  logic          ce_r, ss_r, se_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    rx_r, rx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ovf_frame_r, ovf_frame_nxt;
  logic [GW-1:0] grp_cnt_r, grp_cnt_nxt;
  logic [7:0]    data_r;
  logic          last_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_frame_end_r;
  logic          out_status_r;

  // Combinational control
  logic            out_free;
  logic            acc;
  logic            first;
  logic            take;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   count_after;
  logic            tail_empty;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_fe;
  logic            emit_st;
  logic            chain_pop;
  fctf_chain_ctl_t chain_ctl;
  logic [7:0]      chain_head;
  fctf_state_t     tail_after_data;
  fctf_state_t     tail_after_drop;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign acc      = in_valid && !in_stall;

  // Message position
  assign first       = (count_r == '0) && !ovf_r;
  assign take        = (count_r < CW'(MAX_MSG));
  assign count_inc   = count_r + CW'(1);
  assign count_after = take ? count_inc : count_r;
  assign tail_empty  = !ce_r && se_r;

  assign tail_after_data = ce_r ? ST_CHECK : (!se_r ? ST_END : ST_IDLE);
  assign tail_after_drop = ce_r ? ST_CHECK : (!se_r ? ST_END : ST_FILL);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (first) begin
            state_nxt = ST_DATA;
          end else if (take) begin
            state_nxt = in_last_byte ? tail_after_data : ST_IDLE;
          end else begin
            state_nxt = in_last_byte ? tail_after_drop : ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (out_free) begin
          state_nxt = last_r ? tail_after_data : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (out_free && (grp_cnt_r == GW'(1))) begin
          state_nxt = se_r ? ST_IDLE : ST_END;
        end
      end
      ST_END, ST_FILL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: emitted byte and chain pop
  always_comb begin
    emit      = 1'b0;
    emit_byte = in_data_byte;
    emit_fe   = 1'b0;
    emit_st   = 1'b0;
    chain_pop = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (first) begin
            emit      = 1'b1;
            emit_byte = ss_r ? FCTF_SPACE_BYTE : FCTF_START_BYTE;
          end else if (take) begin
            emit      = 1'b1;
            emit_byte = in_data_byte;
            emit_fe   = in_last_byte && tail_empty;
            emit_st   = in_last_byte && tail_empty && ovf_r;
          end
        end
      end
      ST_DATA: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = data_r;
          emit_fe   = last_r && tail_empty;
          emit_st   = last_r && tail_empty && ovf_frame_r;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = fctf_adjust(chain_head);
          emit_fe   = (grp_cnt_r == GW'(1)) && se_r;
          emit_st   = (grp_cnt_r == GW'(1)) && se_r && ovf_frame_r;
          chain_pop = 1'b1;
        end
      end
      ST_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = FCTF_END_BYTE;
          emit_fe   = 1'b1;
          emit_st   = ovf_frame_r;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = FCTF_FILL_BYTE;
          emit_fe   = 1'b1;
          emit_st   = ovf_frame_r;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Push a group on completion, or the partial group at message end; pass pop on
  always_comb begin
    chain_ctl.pop      = chain_pop;
    chain_ctl.push_val = take ? (rx_r ^ in_data_byte) : rx_r;
    chain_ctl.push     = acc && ((take && (count_inc[2:0] == 3'd0)) ||
                                 (in_last_byte && (count_after[2:0] != 3'd0)));
  end

  // Advance message counters on each request
  always_comb begin
    count_nxt     = count_r;
    rx_nxt        = rx_r;
    ovf_nxt       = ovf_r;
    ovf_frame_nxt = ovf_frame_r;
    if (acc) begin
      if (in_last_byte) begin
        count_nxt     = '0;
        rx_nxt        = '0;
        ovf_nxt       = 1'b0;
        ovf_frame_nxt = ovf_r || !take;
      end else if (take) begin
        count_nxt = count_inc;
        rx_nxt    = (count_inc[2:0] == 3'd0) ? 8'h00 : (rx_r ^ in_data_byte);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // Track stored groups; clear when the frame's final byte leaves
  always_comb begin
    grp_cnt_nxt = grp_cnt_r;
    if (emit && emit_fe) begin
      grp_cnt_nxt = '0;
    end else if (chain_ctl.push) begin
      grp_cnt_nxt = grp_cnt_r + GW'(1);
    end else if (chain_ctl.pop) begin
      grp_cnt_nxt = grp_cnt_r - GW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rx_r        <= '0;
      ovf_r       <= 1'b0;
      ovf_frame_r <= 1'b0;
      grp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rx_r        <= rx_nxt;
      ovf_r       <= ovf_nxt;
      ovf_frame_r <= ovf_frame_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (emit) begin
      out_byte_r      <= emit_byte;
      out_frame_end_r <= emit_fe;
      out_status_r    <= emit_st;
    end
  end

  fctf_chain #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_chain (
    .clk  (clk),
    .ctl  (chain_ctl),
    .head (chain_head)
  );

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ce_r <= 1'b1;
      ss_r <= 1'b0;
      se_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_idx == FCTF_REG_CHECK_ENABLE) begin
        ce_r <= cfg_pwdata[0];
      end
      if (cfg_idx == FCTF_REG_SUPPRESS_START) begin
        ss_r <= cfg_pwdata[0];
      end
      if (cfg_idx == FCTF_REG_SUPPRESS_END) begin
        se_r <= cfg_pwdata[0];
      end
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      FCTF_REG_CHECK_ENABLE:   cfg_prdata = {31'd0, ce_r};
      FCTF_REG_SUPPRESS_START: cfg_prdata = {31'd0, ss_r};
      FCTF_REG_SUPPRESS_END:   cfg_prdata = {31'd0, se_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  // Stored groups never exceed the chain length
  a_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grp_cnt_r <= GW'(NUM_GROUPS))
    else $error("group count beyond chain length");

  // Emitting checks requires at least one stored group
  a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (grp_cnt_r != '0))
    else $error("check state with empty chain");

  // Status only rides on the frame's final byte
  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_frame_end_r) |-> !out_status_r)
    else $error("status set on non-final byte");

  // Byte count stays within the message limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_MSG))
    else $error("byte count beyond limit");

  // Chain is never pushed and popped together
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(chain_ctl.push && chain_ctl.pop))
    else $error("simultaneous push and pop");
`endif

endmodule
